// ===== design/bst_pkg.sv =====
// ============================================================================
// bst_pkg: shared types and codes for the byte stream tokenizer
// Token kinds, scan modes, keyword patterns and the result record that
// travels from the scan core to the output queue.
// ============================================================================
`default_nettype none

package bst_pkg;

    // Scan modes
    localparam logic [1:0] MODE_IDLE   = 2'd0;
    localparam logic [1:0] MODE_NUMBER = 2'd1;
    localparam logic [1:0] MODE_IDENT  = 2'd2;

    // Token kinds
    localparam logic [3:0] KIND_NUMBER = 4'd0;
    localparam logic [3:0] KIND_IDENT  = 4'd1;
    localparam logic [3:0] KIND_TYPE   = 4'd2;
    localparam logic [3:0] KIND_PLUS   = 4'd3;
    localparam logic [3:0] KIND_MINUS  = 4'd4;
    localparam logic [3:0] KIND_MUL    = 4'd5;
    localparam logic [3:0] KIND_DIV    = 4'd6;
    localparam logic [3:0] KIND_EQUALS = 4'd7;
    localparam logic [3:0] KIND_DROP   = 4'd8;
    localparam logic [3:0] KIND_TERM   = 4'd9;
    localparam logic [3:0] KIND_EOF    = 4'd10;
    localparam logic [3:0] KIND_ICHAR  = 4'd11;

    // Type codes
    localparam logic [1:0] TYPE_I64  = 2'd0;
    localparam logic [1:0] TYPE_BOOL = 2'd1;
    localparam logic [1:0] TYPE_STR  = 2'd2;

    // Stored name prefixes, first character in the low byte
    localparam logic [31:0] PREFIX_I64  = 32'h0034_3669;
    localparam logic [31:0] PREFIX_BOOL = 32'h6C6F_6F62;
    localparam logic [31:0] PREFIX_STR  = 32'h0072_7473;

    // Longest name length that the result field can carry
    localparam int unsigned NAME_LEN_SAT = 31;

    typedef struct packed {
        logic [3:0]  kind;
        logic [63:0] number_value;
        logic [1:0]  type_code;
        logic [7:0]  name_char;
        logic [4:0]  name_length;
        logic        last;
    } result_t;

endpackage

`default_nettype wire

// ===== design/bst_scan_core.sv =====
// ============================================================================
// bst_scan_core: per-byte scan step
// Combinational next-state and result logic for one source byte: extends or
// closes a pending number or identifier, and treats a byte that does not continue it as a fresh start.
// ============================================================================
`default_nettype none

module bst_scan_core
    import bst_pkg::*;
#(
    parameter int unsigned MAX_NAME_CHARS = 31,
    parameter int unsigned LEN_W          = $clog2(MAX_NAME_CHARS + 1)
)
(
    input  wire logic [7:0]       char_byte,
    input  wire logic [1:0]       mode,
    input  wire logic [63:0]      acc,
    input  wire logic [LEN_W-1:0] slen,
    input  wire logic [31:0]      prefix,
    output logic [1:0]            mode_next,
    output logic [63:0]           acc_next,
    output logic [LEN_W-1:0]      slen_next,
    output logic [31:0]           prefix_next,
    output result_t               res0,
    output result_t               res1,
    output logic [1:0]            res_count
);

    logic          is_digit;
    logic          is_letter;
    logic          is_space;
    logic          fresh;
    logic          tok_valid;
    result_t       tok;
    logic          start_valid;
    result_t       start_res;
    logic [31:0]   prefix_stored;
    logic [4:0]    len_sat;
    logic [LEN_W+4:0] slen_wide;

    assign is_digit  = (char_byte >= 8'd48) && (char_byte <= 8'd57);
    assign is_letter = ((char_byte >= 8'd65) && (char_byte <= 8'd90)) ||
                       ((char_byte >= 8'd97) && (char_byte <= 8'd122));
    assign is_space  = (char_byte == 8'd32) || (char_byte == 8'd9) ||
                       (char_byte == 8'd13);

    assign slen_wide = (LEN_W + 5)'(slen);
    assign len_sat   = (slen_wide > (LEN_W + 5)'(NAME_LEN_SAT)) ?
                       5'(NAME_LEN_SAT) : slen_wide[4:0];

    // Add the byte into the first four name characters
    always_comb
    begin
        prefix_stored = prefix;
        if (slen < LEN_W'(4))
        begin
            case (slen[1:0])
                2'd0:    prefix_stored[7:0]   = char_byte;
                2'd1:    prefix_stored[15:8]  = char_byte;
                2'd2:    prefix_stored[23:16] = char_byte;
                default: prefix_stored[31:24] = char_byte;
            endcase
        end
    end

    // Pending token, or the echo of a continuing identifier
    always_comb
    begin
        mode_next   = mode;
        acc_next    = acc;
        slen_next   = slen;
        prefix_next = prefix;
        fresh       = 1'b1;
        tok_valid   = 1'b0;
        tok         = '0;

        unique case (mode)
            MODE_NUMBER:
            begin
                if (is_digit)
                begin
                    acc_next = (acc << 3) + (acc << 1) + 64'(char_byte[3:0]);
                    fresh    = 1'b0;
                end
                else
                begin
                    tok_valid        = 1'b1;
                    tok.kind         = KIND_NUMBER;
                    tok.number_value = acc;
                    acc_next         = '0;
                    mode_next        = MODE_IDLE;
                end
            end
            MODE_IDENT:
            begin
                if (is_digit || is_letter)
                begin
                    fresh = 1'b0;
                    if (slen < LEN_W'(MAX_NAME_CHARS))
                    begin
                        slen_next     = slen + LEN_W'(1);
                        prefix_next   = prefix_stored;
                        tok_valid     = 1'b1;
                        tok.kind      = KIND_ICHAR;
                        tok.name_char = char_byte;
                    end
                end
                else
                begin
                    tok_valid       = 1'b1;
                    tok.name_length = len_sat;
                    tok.kind        = KIND_IDENT;
                    if (slen == LEN_W'(3) && prefix == PREFIX_I64)
                    begin
                        tok.kind      = KIND_TYPE;
                        tok.type_code = TYPE_I64;
                    end
                    else if (slen == LEN_W'(4) && prefix == PREFIX_BOOL)
                    begin
                        tok.kind      = KIND_TYPE;
                        tok.type_code = TYPE_BOOL;
                    end
                    else if (slen == LEN_W'(3) && prefix == PREFIX_STR)
                    begin
                        tok.kind      = KIND_TYPE;
                        tok.type_code = TYPE_STR;
                    end
                    slen_next   = '0;
                    prefix_next = '0;
                    mode_next   = MODE_IDLE;
                end
            end
            default:
            begin
                mode_next = MODE_IDLE;
            end
        endcase

        // Fresh start of the byte
        start_valid = 1'b0;
        start_res   = '0;
        if (fresh && !is_space)
        begin
            if (is_digit)
            begin
                mode_next = MODE_NUMBER;
                acc_next  = 64'(char_byte[3:0]);
            end
            else if (is_letter)
            begin
                mode_next           = MODE_IDENT;
                slen_next           = LEN_W'(1);
                prefix_next         = {24'd0, char_byte};
                start_valid         = 1'b1;
                start_res.kind      = KIND_ICHAR;
                start_res.name_char = char_byte;
            end
            else
            begin
                start_valid = 1'b1;
                unique case (char_byte) inside
                    8'd0:          start_res.kind = KIND_EOF;
                    8'd43:         start_res.kind = KIND_PLUS;
                    8'd45:         start_res.kind = KIND_MINUS;
                    8'd42:         start_res.kind = KIND_MUL;
                    8'd47:         start_res.kind = KIND_DIV;
                    8'd61:         start_res.kind = KIND_EQUALS;
                    8'd59:         start_res.kind = KIND_DROP;
                    8'd124, 8'd10: start_res.kind = KIND_TERM;
                    default:       start_valid    = 1'b0;
                endcase
            end
        end
    end

    // Pack the results to the front; the final one carries last
    always_comb
    begin
        res0      = tok_valid ? tok : start_res;
        res0.last = !(tok_valid && start_valid);
        res1      = start_res;
        res1.last = 1'b1;
        res_count = 2'(tok_valid) + 2'(start_valid);
    end

endmodule

`default_nettype wire

// ===== design/byte_stream_tokenizer.sv =====
// ============================================================================
// byte_stream_tokenizer: one-byte-per-cycle lexical tokenizer
// Turns a source byte stream into number, identifier, keyword, operator,
// terminator and end-of-input tokens.
// ============================================================================
// Usage:
//   Input channel (in_valid / in_stall / char_in) takes one source byte per
//   transfer. Output channel (out_valid / out_stall / kind ... last) gives
//   one result per transfer; last marks the final result of a byte.
//   An accepted byte waits in the input register until its results fit in
//   the output queue, where they are registered behind any results it holds.
//   Throughput: one byte per cycle, with no output stall, while each byte gives
//   at most one result. A byte that closes a token and gives its own result
//   (operator, terminator, end of input, letter after a number) adds a result;
//   the input backs off for it unless result-free bytes let the queue drain.
//   The figure is set by the single output port of the result queue.
//   Stall: when the receiver stalls, the queue fills, the scanned byte is
//   held in the input register and in_stall rises; nothing is dropped.
//   Reset: clears the scan state to idle with an empty name and zero
//   accumulator, and empties the input register and the output queue.
// ============================================================================
`default_nettype none

module byte_stream_tokenizer
    import bst_pkg::*;
#(
    parameter int unsigned MAX_NAME_CHARS = 31
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  char_in,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [3:0]       kind,
    output logic [63:0]      number_value,
    output logic [1:0]       type_code,
    output logic [7:0]       name_char,
    output logic [4:0]       name_length,
    output logic             last
);

    localparam int unsigned LEN_W = $clog2(MAX_NAME_CHARS + 1);

    // Input register
    logic             in_full_reg;
    logic [7:0]       byte_reg;

    // Scan state
    logic [1:0]       mode_reg;
    logic [1:0]       mode_next;
    logic [63:0]      acc_reg;
    logic [63:0]      acc_next;
    logic [LEN_W-1:0] slen_reg;
    logic [LEN_W-1:0] slen_next;
    logic [31:0]      prefix_reg;
    logic [31:0]      prefix_next;

    // Output queue: slot 0 faces the port, slot 1 only fills behind it
    logic             q0_valid_reg;
    logic             q1_valid_reg;
    result_t          q0_reg;
    result_t          q1_reg;
    logic             q0_valid_next;
    logic             q1_valid_next;
    result_t          q0_next;
    result_t          q1_next;

    result_t          res0;
    result_t          res1;
    logic [1:0]       res_count;
    logic             pop;
    logic [1:0]       kept;
    logic             fire;
    logic             in_accept;

    bst_scan_core #(
        .MAX_NAME_CHARS (MAX_NAME_CHARS),
        .LEN_W          (LEN_W)
    ) u_scan (
        .char_byte   (byte_reg),
        .mode        (mode_reg),
        .acc         (acc_reg),
        .slen        (slen_reg),
        .prefix      (prefix_reg),
        .mode_next   (mode_next),
        .acc_next    (acc_next),
        .slen_next   (slen_next),
        .prefix_next (prefix_next),
        .res0        (res0),
        .res1        (res1),
        .res_count   (res_count)
    );

    // Entries still held after this cycle's output transfer
    assign pop  = q0_valid_reg && !out_stall;
    assign kept = pop ? 2'(q1_valid_reg) : (2'(q0_valid_reg) + 2'(q1_valid_reg));

    // Scan the held byte only when all of its results fit in the queue
    assign fire      = in_full_reg && ({1'b0, res_count} <= (3'd2 - 3'(kept)));
    assign in_stall  = in_full_reg && !fire;
    assign in_accept = in_valid && !in_stall;

    // Append new results behind whatever stays in the queue
    always_comb
    begin
        q0_valid_next = q0_valid_reg;
        q1_valid_next = q1_valid_reg;
        q0_next       = q0_reg;
        q1_next       = q1_reg;
        if (pop)
        begin
            q0_valid_next = q1_valid_reg;
            q1_valid_next = 1'b0;
            q0_next       = q1_reg;
        end
        if (fire)
        begin
            if (kept == 2'd0)
            begin
                q0_valid_next = (res_count != 2'd0);
                q1_valid_next = (res_count == 2'd2);
                q0_next       = res0;
                q1_next       = res1;
            end
            else if (kept == 2'd1)
            begin
                q1_valid_next = (res_count != 2'd0);
                q1_next       = res0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg  <= 1'b0;
            mode_reg     <= MODE_IDLE;
            acc_reg      <= '0;
            slen_reg     <= '0;
            prefix_reg   <= '0;
            q0_valid_reg <= 1'b0;
            q1_valid_reg <= 1'b0;
        end
        else
        begin
            // Hold the byte until it is scanned; take the next one behind it
            if (in_accept)
                in_full_reg <= 1'b1;
            else if (fire)
                in_full_reg <= 1'b0;
            if (fire)
            begin
                mode_reg   <= mode_next;
                acc_reg    <= acc_next;
                slen_reg   <= slen_next;
                prefix_reg <= prefix_next;
            end
            q0_valid_reg <= q0_valid_next;
            q1_valid_reg <= q1_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
            byte_reg <= char_in;
        q0_reg <= q0_next;
        q1_reg <= q1_next;
    end

    assign out_valid    = q0_valid_reg;
    assign kind         = q0_reg.kind;
    assign number_value = q0_reg.number_value;
    assign type_code    = q0_reg.type_code;
    assign name_char    = q0_reg.name_char;
    assign name_length  = q0_reg.name_length;
    assign last         = q0_reg.last;

`ifndef ASSERT_OFF
    // The back slot of the queue is never filled while the front is empty
    assert property (@(posedge clk) disable iff (!rst_n)
        q1_valid_reg |-> q0_valid_reg)
    else $error("output queue slot 1 occupied with slot 0 empty");

    // A byte with two results lands both of them in the queue
    assert property (@(posedge clk) disable iff (!rst_n)
        (fire && res_count == 2'd2) |=> (q0_valid_reg && q1_valid_reg))
    else $error("two-result byte did not fill both queue slots");

    // Back-pressure on the input only while a byte is waiting to be scanned
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (in_full_reg && !fire))
    else $error("input stalled with no byte waiting");
`endif

endmodule

`default_nettype wire

// ===== test/byte_stream_tokenizer_tb.sv =====
// ============================================================================
// byte_stream_tokenizer_tb: self-checking testbench for the byte tokenizer
// Drives source bytes over the input channel, predicts every token from its
// own copy of the scan state, and checks each output transfer field by field
// against the oldest predicted token. Runs directed token text, then random
// well-formed text mixed with noise under several idle and stall patterns,
// including one long receiver hold-off that backs the block up.
// ============================================================================
`default_nettype none

module byte_stream_tokenizer_tb;
    import bst_pkg::*;

    localparam int unsigned NAME_CAP      = 31;
    localparam int unsigned HOLD_CYCLES   = 300;
    localparam int unsigned SETTLE_CYCLES = 20;
    localparam int unsigned CYCLE_LIMIT   = 300000;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic [7:0]  char_in   = 8'd0;
    logic        out_stall = 1'b0;
    logic        in_stall;
    logic        out_valid;
    logic [3:0]  kind;
    logic [63:0] number_value;
    logic [1:0]  type_code;
    logic [7:0]  name_char;
    logic [4:0]  name_length;
    logic        last;

    // Idle and stall odds in percent, changed per phase by the test tasks
    int unsigned sender_idle_pct  = 0;
    int unsigned receiver_stall_pct = 0;

    // Long hold-off request: flip hold_go to start one
    logic        hold_go   = 1'b0;
    logic        hold_seen = 1'b0;
    int unsigned hold_left = 0;

    int unsigned mismatch_count = 0;
    int unsigned result_count   = 0;
    int unsigned cycle_count    = 0;

    // Predicted tokens, oldest first
    result_t     pending_tokens[$];

    // Scan state mirrored from the block
    logic [1:0]  lex_mode  = MODE_IDLE;
    logic [63:0] num_acc   = 64'd0;
    int unsigned name_len  = 0;
    logic [31:0] name_head = 32'd0;

    always #5 clk = ~clk;

    byte_stream_tokenizer #(
        .MAX_NAME_CHARS (NAME_CAP)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .char_in      (char_in),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .kind         (kind),
        .number_value (number_value),
        .type_code    (type_code),
        .name_char    (name_char),
        .name_length  (name_length),
        .last         (last)
    );

    // ------------------------------------------------------------------------
    // Token prediction
    // ------------------------------------------------------------------------
    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z"));
    endfunction

    function automatic result_t make_token(input logic [3:0] k, input logic [63:0] val,
                                           input logic [1:0] tc, input logic [7:0] ch,
                                           input logic [4:0] len);
        result_t t;
        t.kind         = k;
        t.number_value = val;
        t.type_code    = tc;
        t.name_char    = ch;
        t.name_length  = len;
        t.last         = 1'b0;
        return t;
    endfunction

    // Store one name character; only the first four land in the keyword prefix
    task automatic keep_char(input logic [7:0] c);
        if (name_len < 4)
            name_head[8*name_len +: 8] = c;
        name_len++;
    endtask

    // Advance the mirrored scan state by one accepted byte and queue its tokens
    task automatic tokenize_byte(input logic [7:0] c);
        result_t     made[$];
        logic        fresh;
        logic [4:0]  len_sat;
        fresh = 1'b1;
        case (lex_mode)
            MODE_NUMBER:
                if (is_digit(c))
                begin
                    num_acc = num_acc * 64'd10 + {56'd0, c - 8'd48};
                    fresh   = 1'b0;
                end
                else
                begin
                    made.push_back(make_token(KIND_NUMBER, num_acc, 2'd0, 8'd0, 5'd0));
                    num_acc  = 64'd0;
                    lex_mode = MODE_IDLE;
                end
            MODE_IDENT:
                if (is_digit(c) || is_letter(c))
                begin
                    // Characters past the cap are dropped silently
                    fresh = 1'b0;
                    if (name_len < NAME_CAP)
                    begin
                        keep_char(c);
                        made.push_back(make_token(KIND_ICHAR, 64'd0, 2'd0, c, 5'd0));
                    end
                end
                else
                begin
                    len_sat = (name_len > NAME_LEN_SAT) ? 5'd31 : 5'(name_len);
                    if (name_len == 3 && name_head == PREFIX_I64)
                        made.push_back(make_token(KIND_TYPE, 64'd0, TYPE_I64, 8'd0, len_sat));
                    else if (name_len == 4 && name_head == PREFIX_BOOL)
                        made.push_back(make_token(KIND_TYPE, 64'd0, TYPE_BOOL, 8'd0, len_sat));
                    else if (name_len == 3 && name_head == PREFIX_STR)
                        made.push_back(make_token(KIND_TYPE, 64'd0, TYPE_STR, 8'd0, len_sat));
                    else
                        made.push_back(make_token(KIND_IDENT, 64'd0, 2'd0, 8'd0, len_sat));
                    name_len  = 0;
                    name_head = 32'd0;
                    lex_mode  = MODE_IDLE;
                end
            default:
                lex_mode = MODE_IDLE;
        endcase

        // The closing byte is then scanned as a fresh byte unless it is blank
        if (fresh && !(c == " " || c == 8'd9 || c == 8'd13))
        begin
            lex_mode = MODE_IDLE;
            if (is_digit(c))
            begin
                lex_mode = MODE_NUMBER;
                num_acc  = {56'd0, c - 8'd48};
            end
            else if (is_letter(c))
            begin
                lex_mode  = MODE_IDENT;
                name_len  = 0;
                name_head = 32'd0;
                keep_char(c);
                made.push_back(make_token(KIND_ICHAR, 64'd0, 2'd0, c, 5'd0));
            end
            else
            begin
                case (c)
                    8'd0:  made.push_back(make_token(KIND_EOF, 64'd0, 2'd0, 8'd0, 5'd0));
                    "+":   made.push_back(make_token(KIND_PLUS, 64'd0, 2'd0, 8'd0, 5'd0));
                    "-":   made.push_back(make_token(KIND_MINUS, 64'd0, 2'd0, 8'd0, 5'd0));
                    "*":   made.push_back(make_token(KIND_MUL, 64'd0, 2'd0, 8'd0, 5'd0));
                    "/":   made.push_back(make_token(KIND_DIV, 64'd0, 2'd0, 8'd0, 5'd0));
                    "=":   made.push_back(make_token(KIND_EQUALS, 64'd0, 2'd0, 8'd0, 5'd0));
                    ";":   made.push_back(make_token(KIND_DROP, 64'd0, 2'd0, 8'd0, 5'd0));
                    "|", 8'd10:
                           made.push_back(make_token(KIND_TERM, 64'd0, 2'd0, 8'd0, 5'd0));
                    default: ;
                endcase
            end
        end

        if (made.size() != 0)
            made[made.size() - 1].last = 1'b1;
        foreach (made[i])
            pending_tokens.push_back(made[i]);
    endtask

    // ------------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------------

    // Offer one byte, hold it until the transfer, then predict its tokens
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        char_in  <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        tokenize_byte(b);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    // Send a name of the given length: a letter, then letters and digits
    task automatic send_name(input int unsigned len);
        logic [7:0] c;
        for (int unsigned i = 0; i < len; i++)
        begin
            if (i != 0 && $urandom_range(3) == 0)
                c = 8'd48 + 8'($urandom_range(9));
            else
                c = 8'($urandom_range(25)) + ($urandom_range(1) ? 8'd65 : 8'd97);
            send_byte(c);
        end
    endtask

    // Mostly well-formed token text with random content, plus some noise
    task automatic send_random_text(input int unsigned count);
        string       words[6];
        string       ops;
        string       blanks;
        int unsigned sent;
        int unsigned pick;
        int unsigned n;
        words  = '{"i64", "bool", "str", "i6", "bools", "stR"};
        ops    = "+-*/=;\n|";
        blanks = " \t\r";
        sent   = 0;
        while (sent < count)
        begin
            pick = $urandom_range(99);
            if (pick < 25)
            begin
                // Long digit runs, up to 25 digits, can wrap the accumulator
                n = ($urandom_range(9) == 0) ? $urandom_range(25, 18) : $urandom_range(4, 1);
                for (int unsigned i = 0; i < n; i++)
                    send_byte(8'd48 + 8'($urandom_range(9)));
            end
            else if (pick < 50)
            begin
                n = ($urandom_range(9) == 0) ? $urandom_range(40, 28) : $urandom_range(8, 1);
                send_name(n);
            end
            else if (pick < 58)
            begin
                pick = $urandom_range(5);
                n    = words[pick].len();
                send_text(words[pick]);
            end
            else if (pick < 78)
            begin
                n = 1;
                send_byte(ops[$urandom_range(ops.len() - 1)]);
            end
            else if (pick < 88)
            begin
                n = 1;
                send_byte(blanks[$urandom_range(2)]);
            end
            else if (pick < 92)
            begin
                n = 1;
                send_byte(8'd0);
            end
            else
            begin
                n = 1;
                send_byte(8'($urandom_range(255)));
            end
            sent += n;
        end
    endtask

    // ------------------------------------------------------------------------
    // Output side
    // ------------------------------------------------------------------------

    // Stall at random, or hold off for a long stretch when asked
    always @(posedge clk)
    begin
        if (hold_go != hold_seen)
        begin
            hold_seen <= hold_go;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < receiver_stall_pct);
    end

    task automatic report(input string msg);
        $display("[%0t] mismatch at result %0d: %s", $realtime, result_count, msg);
        mismatch_count++;
    endtask

    task automatic compare_field(input string field, input logic [63:0] got,
                                 input logic [63:0] want);
        if (got !== want)
            report($sformatf("%s is %0h, predicted %0h", field, got, want));
    endtask

    // Check every output transfer against the oldest predicted token
    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_tokens.size() == 0)
                report("result with no token predicted");
            else
            begin
                want = pending_tokens.pop_front();
                compare_field("kind", 64'(kind), 64'(want.kind));
                compare_field("number_value", number_value, want.number_value);
                compare_field("type_code", 64'(type_code), 64'(want.type_code));
                compare_field("name_char", 64'(name_char), 64'(want.name_char));
                compare_field("name_length", 64'(name_length), 64'(want.name_length));
                compare_field("last", 64'(last), 64'(want.last));
            end
            result_count++;
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d tokens outstanding",
                     cycle_count, pending_tokens.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Keywords, each closed by a blank that gives nothing more
    task automatic test_keywords();
        send_text("i64 bool\tstr\r");
    endtask

    // Every operator and both terminators; a number and a name closed by one
    task automatic test_operators();
        send_text("7+x1-*/=;\n|");
    endtask

    // Unknown top byte closes a number, end of input closes a name
    task automatic test_extremes();
        send_byte("9");
        send_byte(8'hFF);
        send_byte("z");
        send_byte(8'd0);
    endtask

    // Names at, just over and well over the stored cap
    task automatic test_long_names();
        send_name(NAME_CAP);
        send_byte("+");
        send_name(NAME_CAP + 1);
        send_byte(" ");
        send_name(45);
        send_byte(8'd0);
    endtask

    task automatic test_random_phase(input int unsigned idle_pct, input int unsigned stall_pct,
                                     input int unsigned count);
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        send_random_text(count);
    endtask

    // Hold off the receiver while bytes keep coming, so the input backs up
    task automatic test_backpressure();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        hold_go            = ~hold_go;
        send_random_text(80);
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_keywords();
        test_operators();
        test_extremes();
        test_long_names();
        test_random_phase(0, 0, 160);
        test_random_phase(55, 0, 240);
        test_random_phase(0, 55, 240);
        test_random_phase(23, 23, 240);
        test_backpressure();

        // Drop valid and drain whatever is still in flight
        in_valid <= 1'b0;
        receiver_stall_pct = 0;
        while (pending_tokens.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
design/bst_pkg.sv
design/bst_scan_core.sv
design/byte_stream_tokenizer.sv
test/byte_stream_tokenizer_tb.sv
